>>> design/cfph_pkg.sv
// ----------------------------------------------------------------------------
// cfph_pkg
// Shared types, constants and arithmetic helpers for the candle flicker
// pixel colour pipeline.
// ----------------------------------------------------------------------------
package cfph_pkg;

  localparam int NSTAGE    = 14;
  localparam int DIV_STEPS = 8;
  localparam int DIV_FIRST = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RED,
    REG_BASE_GREEN,
    REG_BASE_BLUE,
    REG_HUE_VARIATION,
    REG_SEED_BASE,
    REG_START_INTENSITY,
    REG_TARGET_INTENSITY,
    REG_RAMP_DURATION
  } reg_idx_t;

  localparam logic [7:0]  LINE_MUL    = 8'd41;
  localparam logic [15:0] PIX_MUL     = 16'd109;
  localparam logic [15:0] FRAME_MUL   = 16'd251;
  localparam logic [15:0] SALT_MUL    = 16'd199;
  localparam logic [15:0] HASH_MUL    = 16'd2053;
  localparam logic [15:0] HASH_ADD    = 16'd13849;
  localparam logic [7:0]  SALT_HUE    = 8'd3;
  localparam logic [7:0]  SALT_BRIGHT = 8'd17;
  localparam logic [7:0]  SECTOR      = 8'd43;
  localparam logic [7:0]  HUE_GREEN   = 8'd85;
  localparam logic [7:0]  HUE_BLUE    = 8'd171;
  localparam logic [7:0]  HUE_WRAP    = 8'd255;
  localparam logic [7:0]  NOISE_MID   = 8'd127;
  localparam logic [7:0]  FACTOR_BASE = 8'd145;
  localparam logic [7:0]  FACTOR_SPAN = 8'd110;
  localparam logic [7:0]  SCALE_MAX   = 8'd255;

  typedef struct packed {
    logic [1:0]  line;
    logic [6:0]  pixel;
    logic [15:0] frame;
    logic [31:0] elapsed;
    logic [15:0] hv3;
    logic [15:0] hv17;
    logic [7:0]  n3;
    logic [7:0]  n17;
    logic        var_neg;
    logic [15:0] var_mag;
    logic [7:0]  var_q;
    logic [15:0] fac_prod;
    logic [7:0]  factor;
    logic [7:0]  v0;
    logic [15:0] vf_prod;
    logic [7:0]  vf;
    logic [14:0] h_rem;
    logic [7:0]  h_div;
    logic [7:0]  h_q;
    logic        h_neg;
    logic [7:0]  h_off;
    logic        h_zero;
    logic [15:0] s_rem;
    logic [7:0]  s_div;
    logic [7:0]  s_q;
    logic        s_zero;
    logic [23:0] p_rem;
    logic [15:0] p_div;
    logic [7:0]  p_q;
    logic        p_done;
    logic        p_zero;
    logic        r_neg;
    logic [15:0] r_prod;
    logic [7:0]  intensity;
    logic [15:0] b_prod;
    logic [7:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  bright;
  } pipe_t;

  // xor/shift mixing of the hash input
  function automatic logic [15:0] hash_mix(input logic [7:0] seed, input logic [1:0] line,
                                           input logic [6:0] pixel, input logic [15:0] frame,
                                           input logic [7:0] salt);
    logic [15:0] v;
    logic [7:0]  lmul;
    lmul = 8'({6'd0, line} * LINE_MUL);
    v = {seed, lmul};
    v = v ^ 16'({9'd0, pixel} * PIX_MUL);
    v = v ^ 16'(frame * FRAME_MUL);
    v = v ^ 16'({8'd0, salt} * SALT_MUL);
    v = v ^ (v << 7);
    v = v ^ (v >> 9);
    return v;
  endfunction

  function automatic logic [7:0] hash_out(input logic [15:0] v);
    logic [15:0] m;
    m = 16'(v * HASH_MUL + HASH_ADD);
    return m[15:8];
  endfunction

  // floor(x / 255), exact for x below 255 * 256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

>>> design/candle_flicker_pixel_hsv.sv
// ----------------------------------------------------------------------------
// candle_flicker_pixel_hsv
// Candle flicker colour per pixel: base hue and saturation, hashed hue
// wobble, hashed brightness flicker and a ramped intensity, as one pipeline.
// ----------------------------------------------------------------------------
// throughput: one word per cycle without out_stall; the three restoring dividers
// take one quotient bit per stage over eight stages, so nothing iterates in place
// stalled stages keep their word, empty stages ahead of a stall keep filling
// reset (rst, synchronous): all stage valid bits and configuration registers clear
module candle_flicker_pixel_hsv (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cfph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfph_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         line_index,
  input  logic [6:0]                         pixel_index,
  input  logic [15:0]                        frame_count,
  input  logic [31:0]                        elapsed_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         hue,
  output logic [7:0]                         saturation,
  output logic [7:0]                         brightness
);
  import cfph_pkg::*;

  logic [7:0]  base_red;
  logic [7:0]  base_green;
  logic [7:0]  base_blue;
  logic [7:0]  hue_variation;
  logic [7:0]  seed_base;
  logic [7:0]  start_intensity;
  logic [7:0]  target_intensity;
  logic [15:0] ramp_duration;

  pipe_t             p   [NSTAGE];
  pipe_t             nxt [NSTAGE];
  logic [NSTAGE-1:0] v;
  logic [NSTAGE:0]   rdy;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_red         <= '0;
      base_green       <= '0;
      base_blue        <= '0;
      hue_variation    <= '0;
      seed_base        <= '0;
      start_intensity  <= '0;
      target_intensity <= '0;
      ramp_duration    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_RED:         base_red         <= cfg_data[7:0];
        REG_BASE_GREEN:       base_green       <= cfg_data[7:0];
        REG_BASE_BLUE:        base_blue        <= cfg_data[7:0];
        REG_HUE_VARIATION:    hue_variation    <= cfg_data[7:0];
        REG_SEED_BASE:        seed_base        <= cfg_data[7:0];
        REG_START_INTENSITY:  start_intensity  <= cfg_data[7:0];
        REG_TARGET_INTENSITY: target_intensity <= cfg_data[7:0];
        REG_RAMP_DURATION:    ramp_duration    <= cfg_data;
        default: ;
      endcase
    end
  end

  // per stage hold: a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[NSTAGE] = !out_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_comb begin
    logic [7:0]        hi;
    logic [7:0]        lo;
    logic [7:0]        seed;
    logic signed [8:0] num;
    logic [7:0]        nmag;
    logic [14:0]       hd;
    logic [15:0]       sd;
    logic [23:0]       pd;
    logic [7:0]        mag3;
    logic signed [9:0] hs;
    logic [7:0]        hue0;
    logic [7:0]        var8;
    logic [7:0]        prog;
    logic [7:0]        dmag;
    logic [7:0]        rq;

    nxt[0] = '0;
    nxt[0].line    = line_index;
    nxt[0].pixel   = pixel_index;
    nxt[0].frame   = frame_count;
    nxt[0].elapsed = elapsed_ms;
    for (int k = 1; k < NSTAGE; k++) begin
      nxt[k] = p[k-1];
    end

    // stage 1: hash mixing, divider set-up
    hi = (base_red > base_green) ? base_red : base_green;
    hi = (hi > base_blue) ? hi : base_blue;
    lo = (base_red < base_green) ? base_red : base_green;
    lo = (lo < base_blue) ? lo : base_blue;
    seed = 8'(seed_base + {6'd0, p[0].line});
    nxt[1].hv3  = hash_mix(seed, p[0].line, p[0].pixel, p[0].frame, SALT_HUE);
    nxt[1].hv17 = hash_mix(seed, p[0].line, p[0].pixel, p[0].frame, SALT_BRIGHT);
    if (hi == base_red) begin
      num = $signed({1'b0, base_green}) - $signed({1'b0, base_blue});
      nxt[1].h_off = '0;
    end else if (hi == base_green) begin
      num = $signed({1'b0, base_blue}) - $signed({1'b0, base_red});
      nxt[1].h_off = HUE_GREEN;
    end else begin
      num = $signed({1'b0, base_red}) - $signed({1'b0, base_green});
      nxt[1].h_off = HUE_BLUE;
    end
    nmag = num[8] ? 8'(-num) : num[7:0];
    nxt[1].h_neg  = num[8];
    nxt[1].h_rem  = 15'({7'd0, nmag} * {7'd0, SECTOR});
    nxt[1].h_div  = 8'(hi - lo);
    nxt[1].h_zero = (hi == lo);
    nxt[1].h_q    = '0;
    nxt[1].s_rem  = 16'({8'd0, 8'(hi - lo)} * {8'd0, SCALE_MAX});
    nxt[1].s_div  = hi;
    nxt[1].s_zero = (hi == '0);
    nxt[1].s_q    = '0;
    nxt[1].v0     = hi;
    nxt[1].p_zero = (ramp_duration == '0);
    nxt[1].p_done = (p[0].elapsed >= {16'd0, ramp_duration});
    nxt[1].p_rem  = nxt[1].p_done ? '0
                                  : 24'({8'd0, p[0].elapsed[15:0]} * {16'd0, SCALE_MAX});
    nxt[1].p_div  = ramp_duration;
    nxt[1].p_q    = '0;

    // stages 2 to 9: one quotient bit per stage for each divider
    for (int j = 0; j < DIV_STEPS; j++) begin
      hd = 15'({7'd0, p[DIV_FIRST+j-1].h_div} << (DIV_STEPS - 1 - j));
      sd = 16'({8'd0, p[DIV_FIRST+j-1].s_div} << (DIV_STEPS - 1 - j));
      pd = 24'({8'd0, p[DIV_FIRST+j-1].p_div} << (DIV_STEPS - 1 - j));
      if (p[DIV_FIRST+j-1].h_rem >= hd) begin
        nxt[DIV_FIRST+j].h_rem = p[DIV_FIRST+j-1].h_rem - hd;
        nxt[DIV_FIRST+j].h_q   = {p[DIV_FIRST+j-1].h_q[6:0], 1'b1};
      end else begin
        nxt[DIV_FIRST+j].h_q   = {p[DIV_FIRST+j-1].h_q[6:0], 1'b0};
      end
      if (p[DIV_FIRST+j-1].s_rem >= sd) begin
        nxt[DIV_FIRST+j].s_rem = p[DIV_FIRST+j-1].s_rem - sd;
        nxt[DIV_FIRST+j].s_q   = {p[DIV_FIRST+j-1].s_q[6:0], 1'b1};
      end else begin
        nxt[DIV_FIRST+j].s_q   = {p[DIV_FIRST+j-1].s_q[6:0], 1'b0};
      end
      if (p[DIV_FIRST+j-1].p_rem >= pd) begin
        nxt[DIV_FIRST+j].p_rem = p[DIV_FIRST+j-1].p_rem - pd;
        nxt[DIV_FIRST+j].p_q   = {p[DIV_FIRST+j-1].p_q[6:0], 1'b1};
      end else begin
        nxt[DIV_FIRST+j].p_q   = {p[DIV_FIRST+j-1].p_q[6:0], 1'b0};
      end
    end

    // stage 2: hash finish
    nxt[2].n3  = hash_out(p[1].hv3);
    nxt[2].n17 = hash_out(p[1].hv17);

    // stage 3: noise products
    nxt[3].var_neg  = (p[2].n3 < NOISE_MID);
    mag3 = nxt[3].var_neg ? 8'(NOISE_MID - p[2].n3) : 8'(p[2].n3 - NOISE_MID);
    nxt[3].var_mag  = 16'({8'd0, mag3} * {8'd0, hue_variation});
    nxt[3].fac_prod = 16'({8'd0, p[2].n17} * {8'd0, FACTOR_SPAN});

    // stage 4: scale by 1/255
    nxt[4].var_q  = div255(p[3].var_mag);
    nxt[4].factor = 8'(FACTOR_BASE + div255(p[3].fac_prod));

    // stages 5 and 6: flicker on the base value
    nxt[5].vf_prod = 16'({8'd0, p[4].v0} * {8'd0, p[4].factor});
    nxt[6].vf      = div255(p[5].vf_prod);

    // stage 10: hue, saturation, ramp product
    hs = $signed({2'b0, p[9].h_off}) + (p[9].h_neg ? -$signed({2'b0, p[9].h_q})
                                                   : $signed({2'b0, p[9].h_q}));
    if (hs < 0) begin
      hs = hs + $signed({2'b0, HUE_WRAP});
    end
    hue0 = p[9].h_zero ? '0 : hs[7:0];
    var8 = p[9].var_neg ? 8'(8'd0 - p[9].var_q) : p[9].var_q;
    nxt[10].hue = 8'(hue0 + var8);
    nxt[10].sat = p[9].s_zero ? '0 : p[9].s_q;
    prog = p[9].p_done ? SCALE_MAX : p[9].p_q;
    nxt[10].r_neg = (target_intensity < start_intensity);
    dmag = nxt[10].r_neg ? 8'(start_intensity - target_intensity)
                         : 8'(target_intensity - start_intensity);
    nxt[10].r_prod = 16'({8'd0, dmag} * {8'd0, prog});

    // stage 11: ramped intensity
    rq = div255(p[10].r_prod);
    if (p[10].p_zero) begin
      nxt[11].intensity = target_intensity;
    end else if (p[10].r_neg) begin
      nxt[11].intensity = 8'(start_intensity - rq);
    end else begin
      nxt[11].intensity = 8'(start_intensity + rq);
    end

    // stages 12 and 13: intensity on the flickered value
    nxt[12].b_prod = 16'({8'd0, p[11].vf} * {8'd0, p[11].intensity});
    nxt[13].bright = div255(p[12].b_prod);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        p[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign out_valid  = v[NSTAGE-1];
  assign hue        = p[NSTAGE-1].hue;
  assign saturation = p[NSTAGE-1].sat;
  assign brightness = p[NSTAGE-1].bright;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("input stalled with a bubble in the pipeline");

  a_progress_below_end: assert property (@(posedge clk) disable iff (rst)
    (v[9] && !p[9].p_done) |-> (p[9].p_q != SCALE_MAX))
    else $error("ramp progress reached the end before the ramp finished");

  a_hue_step_bound: assert property (@(posedge clk) disable iff (rst)
    (v[9] && !p[9].h_zero) |-> (p[9].h_q <= SECTOR))
    else $error("hue sector offset beyond one sector");

  a_factor_floor: assert property (@(posedge clk) disable iff (rst)
    v[4] |-> (p[4].factor >= FACTOR_BASE))
    else $error("flicker factor below its floor");

endmodule
